### design/dominator_set_engine_defines.svh
// Assertion macros shared by the dominator set engine checker.
// Depends on nothing; users must have clk and arst_n in scope.
`ifndef DOMINATOR_SET_ENGINE_DEFINES_SVH
`define DOMINATOR_SET_ENGINE_DEFINES_SVH

// Generic clocked assertion, disabled while reset is asserted.
`define DSE_ASSERT_PROP(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same-cycle implication.
`define DSE_ASSERT_IMPL(label, ante, cons, msg) \
	`DSE_ASSERT_PROP(label, (ante) |-> (cons), msg)

// Next-cycle implication.
`define DSE_ASSERT_NEXT(label, ante, cons, msg) \
	`DSE_ASSERT_PROP(label, (ante) |=> (cons), msg)

`endif

### design/dse_pkg.sv
// Package for the dominator set engine: opcodes, sequencer states and
// the stream field layout. Depends on nothing.
package dse_pkg;

	localparam int CFG_W     = 6;
	localparam int S_TDATA_W = 16;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 48;

	localparam int BLK_W  = 5;
	localparam int SET_W  = 32;

	// Input tdata layout.
	localparam int FROM_LSB = 0;
	localparam int TO_LSB   = 5;

	// Output tdata layout.
	localparam int M_IDX_LSB  = 0;
	localparam int M_SET_LSB  = 5;
	localparam int M_IDOM_LSB = 37;
	localparam int M_HAS_BIT  = 42;

	typedef enum logic [1:0] {
		OP_ADD_EDGE = 2'd0,
		OP_COMPUTE  = 2'd1,
		OP_CLEAR    = 2'd2
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_SCAN,
		ST_DRAIN,
		ST_WRITE,
		ST_REP_ROW,
		ST_REP_WAIT,
		ST_REP_SCAN,
		ST_REP_DRAIN,
		ST_EMIT
	} state_t;

endpackage

### design/dominator_set_engine.sv
// Dominator set engine: edges load one input transaction per cycle while the engine is idle.
// A compute initialises the set row of each block up to the clamped block count, then
// runs passes over the rows, repeated until no row changes, then reports every block
// in turn, waiting out any output stall. The set memory has one read port, which bounds
// each row scan. Reset clears the sequencer, the edge matrix and sets the block count to 1;
// the set memory is not cleared, since every row in use is written at the start of a compute.
module dominator_set_engine #(
	parameter int MAX_BLOCKS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [dse_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// from_block[4:0], to_block[9:5], zero pad above
	input  logic [dse_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// op[1:0]
	input  logic [dse_pkg::S_TUSER_W-1:0] s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// block_index[4:0], dominator_set[36:5], immediate_dominator[41:37],
	// has_immediate[42], zero pad above
	output logic [dse_pkg::M_TDATA_W-1:0] m_axis_tdata,
	output logic                          m_axis_tlast
);
	import dse_pkg::*;

	localparam int NB = (MAX_BLOCKS < 32) ? MAX_BLOCKS : 32;
	localparam int IW = $clog2(NB);
	localparam int CW = $clog2(NB + 1);

	state_t state_q, state_d;

	logic [CFG_W-1:0] blk_total_q;
	logic [CW-1:0]    n_eff;
	logic [IW-1:0]    n_last;
	logic [NB-1:0]    mask;

	logic [NB-1:0] pred_q [NB];
	logic [NB-1:0] pred_row;

	logic [IW-1:0] i_q, p_q, p_s1, best_q;
	logic          v_s1, rep_s1, any_q, have_q, changed_q, m_valid_q;
	logic [NB-1:0] acc_q, old_q, row_q, onehot_i, strict_row, nv;
	logic          diff;

	logic [BLK_W-1:0] out_idx_q, out_idom_q;
	logic [SET_W-1:0] out_set_q;
	logic             out_has_q, out_last_q;

	logic [BLK_W-1:0] from_blk, to_blk;
	logic             in_fire, edge_ok, out_free;
	op_t              in_op;

	logic          ram_we;
	logic [IW-1:0] ram_raddr;
	logic [NB-1:0] ram_wdata, ram_rdata;

	logic issue, issue_rep, i_inc, i_set1, i_clr, p_inc, row_init, chg_clr, chg_upd;
	logic cap_row, out_load;

	// Effective block count, clamped to 1..NB.
	always_comb begin
		if (blk_total_q == '0) begin
			n_eff = CW'(1);
		end else if (blk_total_q > CFG_W'(NB)) begin
			n_eff = CW'(NB);
		end else begin
			n_eff = CW'(blk_total_q);
		end
		n_last = IW'(n_eff - CW'(1));
		for (int k = 0; k < NB; k++) begin
			mask[k] = (CW'(k) < n_eff);
		end
	end

	assign from_blk = s_axis_tdata[FROM_LSB +: BLK_W];
	assign to_blk   = s_axis_tdata[TO_LSB +: BLK_W];
	assign in_op    = op_t'(s_axis_tuser);
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign edge_ok  = (6'(from_blk) < 6'(n_eff)) && (6'(to_blk) < 6'(n_eff));
	assign out_free = !m_valid_q || m_axis_tready;

	assign pred_row   = pred_q[i_q] & mask;
	assign onehot_i   = NB'(1) << i_q;
	assign strict_row = row_q & ~onehot_i;
	assign nv   = ((any_q ? acc_q : '0) | onehot_i) & mask;
	assign diff = (nv != old_q);

	dse_ram #(
		.WIDTH(NB),
		.DEPTH(NB)
	) u_dom_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(i_q),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_wdata = nv;
		ram_raddr = (state_q == ST_REP_ROW) ? i_q : p_q;
		issue     = 1'b0;
		issue_rep = 1'b0;
		i_inc     = 1'b0;
		i_set1    = 1'b0;
		i_clr     = 1'b0;
		p_inc     = 1'b0;
		row_init  = 1'b0;
		chg_clr   = 1'b0;
		chg_upd   = 1'b0;
		cap_row   = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire && in_op == OP_COMPUTE) begin
					i_clr   = 1'b1;
					state_d = ST_INIT;
				end
			end
			ST_INIT: begin
				ram_we    = 1'b1;
				ram_wdata = (i_q == '0) ? NB'(1) : mask;
				if (i_q == n_last) begin
					if (n_last == '0) begin
						i_clr   = 1'b1;
						state_d = ST_REP_ROW;
					end else begin
						i_set1   = 1'b1;
						row_init = 1'b1;
						chg_clr  = 1'b1;
						state_d  = ST_SCAN;
					end
				end else begin
					i_inc = 1'b1;
				end
			end
			ST_SCAN: begin
				issue = 1'b1;
				if (p_q == n_last) begin
					state_d = ST_DRAIN;
				end else begin
					p_inc = 1'b1;
				end
			end
			ST_DRAIN: begin
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				ram_we   = 1'b1;
				chg_upd  = 1'b1;
				row_init = 1'b1;
				if (i_q == n_last) begin
					if (changed_q || diff) begin
						i_set1  = 1'b1;
						chg_clr = 1'b1;
						state_d = ST_SCAN;
					end else begin
						i_clr   = 1'b1;
						state_d = ST_REP_ROW;
					end
				end else begin
					i_inc   = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_REP_ROW: begin
				state_d = ST_REP_WAIT;
			end
			ST_REP_WAIT: begin
				cap_row = 1'b1;
				state_d = ST_REP_SCAN;
			end
			ST_REP_SCAN: begin
				issue_rep = 1'b1;
				if (p_q == n_last) begin
					state_d = ST_REP_DRAIN;
				end else begin
					p_inc = 1'b1;
				end
			end
			ST_REP_DRAIN: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					if (i_q == n_last) begin
						state_d = ST_IDLE;
					end else begin
						i_inc   = 1'b1;
						state_d = ST_REP_ROW;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers: counters, flags, edge matrix and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_total_q <= CFG_W'(1);
			i_q         <= '0;
			p_q         <= '0;
			v_s1        <= 1'b0;
			rep_s1      <= 1'b0;
			any_q       <= 1'b0;
			have_q      <= 1'b0;
			changed_q   <= 1'b0;
			m_valid_q   <= 1'b0;
			for (int r = 0; r < NB; r++) begin
				pred_q[r] <= '0;
			end
		end else begin
			if (cfg_we) begin
				blk_total_q <= cfg_wdata;
			end

			if (in_fire) begin
				unique case (in_op)
					OP_ADD_EDGE: begin
						if (edge_ok) begin
							pred_q[to_blk[IW-1:0]][from_blk[IW-1:0]] <= 1'b1;
						end
					end
					OP_CLEAR: begin
						for (int r = 0; r < NB; r++) begin
							pred_q[r] <= '0;
						end
					end
					default: begin
					end
				endcase
			end

			if (i_clr) begin
				i_q <= '0;
			end else if (i_set1) begin
				i_q <= IW'(1);
			end else if (i_inc) begin
				i_q <= i_q + IW'(1);
			end

			if (row_init || cap_row) begin
				p_q <= '0;
			end else if (p_inc) begin
				p_q <= p_q + IW'(1);
			end

			v_s1   <= issue || issue_rep;
			rep_s1 <= issue_rep;

			if (chg_clr) begin
				changed_q <= 1'b0;
			end else if (chg_upd && diff) begin
				changed_q <= 1'b1;
			end

			if (row_init) begin
				any_q <= 1'b0;
			end else if (v_s1 && !rep_s1 && pred_row[p_s1]) begin
				any_q <= 1'b1;
			end

			// The first strict dominator seeds the choice; later ones replace it
			// when the current choice dominates them.
			if (cap_row) begin
				have_q <= 1'b0;
			end else if (v_s1 && rep_s1 && strict_row[p_s1]) begin
				have_q <= 1'b1;
			end

			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers of the shared scan unit and the output stage.
	always_ff @(posedge clk) begin
		p_s1 <= p_q;
		if (row_init) begin
			acc_q <= mask;
		end else if (v_s1 && !rep_s1) begin
			if (pred_row[p_s1]) begin
				acc_q <= acc_q & ram_rdata;
			end
			if (p_s1 == i_q) begin
				old_q <= ram_rdata;
			end
		end

		if (cap_row) begin
			row_q  <= ram_rdata;
			best_q <= '0;
		end else if (v_s1 && rep_s1 && strict_row[p_s1]) begin
			if (!have_q || ram_rdata[best_q]) begin
				best_q <= p_s1;
			end
		end

		if (out_load) begin
			out_idx_q  <= BLK_W'(i_q);
			out_set_q  <= SET_W'(row_q);
			out_idom_q <= BLK_W'(best_q);
			out_has_q  <= have_q;
			out_last_q <= (i_q == n_last);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {(M_TDATA_W - M_HAS_BIT - 1)'(0), out_has_q, out_idom_q,
		out_set_q, out_idx_q};

endmodule

### design/dse_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the dominator set rows.
module dse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### design/dse_checker.sv
// Port-level checker for the dominator set engine, bound to the top level.
// Depends on dse_pkg and dominator_set_engine_defines.svh.
`include "dominator_set_engine_defines.svh"

module dse_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic [dse_pkg::S_TUSER_W-1:0] s_axis_tuser,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [dse_pkg::M_TDATA_W-1:0] m_axis_tdata,
	input logic                          m_axis_tlast
);
	import dse_pkg::*;

	logic s_fire;
	assign s_fire = s_axis_tvalid && s_axis_tready;

	// A stalled result must hold still.
	`DSE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

	// A compute transaction keeps the input side busy while it runs.
	`DSE_ASSERT_NEXT(a_busy_after_compute, s_fire && s_axis_tuser == OP_COMPUTE, !s_axis_tready, "input ready right after compute")

	// Edge, clear and unused ops never create results.
	`DSE_ASSERT_NEXT(a_no_result_from_load, s_fire && s_axis_tuser != OP_COMPUTE && !m_axis_tvalid, !m_axis_tvalid, "result without compute")

	// The entry block is dominated only by itself and has no immediate dominator.
	`DSE_ASSERT_IMPL(a_entry_self, m_axis_tvalid && m_axis_tdata[M_IDX_LSB +: BLK_W] == '0, m_axis_tdata[M_SET_LSB +: SET_W] == SET_W'(1) && !m_axis_tdata[M_HAS_BIT], "bad entry block result")

	// Without a strict dominator the immediate dominator field reads zero.
	`DSE_ASSERT_IMPL(a_idom_zero, m_axis_tvalid && !m_axis_tdata[M_HAS_BIT], m_axis_tdata[M_IDOM_LSB +: BLK_W] == '0, "immediate dominator set without strict dominator")

endmodule

bind dominator_set_engine dse_checker u_dse_checker (.*);

### tb/sv/dominator_set_engine_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for dominator_set_engine: loads random and directed graphs,
// predicts dominator sets and immediate dominators, and checks every reported block.
// Depends on dse_pkg and the engine RTL only.
module dominator_set_engine_test;
	import dse_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 2000000;
	localparam int unsigned HOLD_OFF_CYCLES = 1500;
	localparam int unsigned SETTLE_CYCLES = 16;

	typedef struct {
		logic [BLK_W-1:0] block_index;
		logic [SET_W-1:0] dominator_set;
		logic [BLK_W-1:0] immediate_dominator;
		logic             has_immediate;
		logic             last;
	} dom_report_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_W-1:0]     cfg_wdata;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata;
	logic [S_TUSER_W-1:0] s_axis_tuser;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic                 m_axis_tlast;

	// Shadow copy of the engine state.
	logic [SET_W-1:0] edge_rows[32];
	logic [SET_W-1:0] dom_rows[32];
	logic [CFG_W-1:0] shadow_blk_total;

	dom_report_t expected_reports[$];
	dom_report_t seen_report;
	int          mismatch_count;
	int unsigned cycle_count;
	int unsigned send_gap_pct;
	int unsigned recv_stall_pct;
	bit          hold_off_req;
	int unsigned hold_left;

	dominator_set_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	function automatic int effective_blocks();
		int n;
		n = int'(shadow_blk_total);
		if (n < 1) n = 1;
		if (n > 32) n = 32;
		return n;
	endfunction

	// Iterative fixed point, rows updated in place in ascending order, then the report.
	function automatic void predict_dominators();
		int n, i, j, p;
		logic [SET_W-1:0] mask, preds, acc, nv, strict_set;
		logic any_pred, changed, have;
		int best;
		dom_report_t r;
		n = effective_blocks();
		mask = (n >= 32) ? '1 : ((32'd1 << n) - 32'd1);
		dom_rows[0] = 32'd1;
		for (i = 1; i < n; i++) dom_rows[i] = mask;
		changed = 1'b1;
		while (changed) begin
			changed = 1'b0;
			for (i = 1; i < n; i++) begin
				preds = edge_rows[i] & mask;
				acc = mask;
				any_pred = 1'b0;
				for (p = 0; p < 32; p++) begin
					if (preds[p]) begin
						acc &= dom_rows[p];
						any_pred = 1'b1;
					end
				end
				if (!any_pred) acc = '0;
				nv = (acc | (32'd1 << i)) & mask;
				if (nv != dom_rows[i]) begin
					dom_rows[i] = nv;
					changed = 1'b1;
				end
			end
		end
		for (i = 0; i < n; i++) begin
			strict_set = dom_rows[i] & ~(32'd1 << i);
			best = 0;
			have = 1'b0;
			for (j = 0; j < n; j++) begin
				if (strict_set[j]) begin
					if (!have) begin
						best = j;
						have = 1'b1;
					end else if (dom_rows[j][best]) begin
						best = j;
					end
				end
			end
			r.block_index = i[BLK_W-1:0];
			r.dominator_set = dom_rows[i];
			r.immediate_dominator = have ? best[BLK_W-1:0] : '0;
			r.has_immediate = have;
			r.last = (i + 1 == n);
			expected_reports.push_back(r);
		end
	endfunction

	function automatic void apply_item(logic [1:0] op, logic [BLK_W-1:0] from_blk,
		logic [BLK_W-1:0] to_blk);
		int n;
		n = effective_blocks();
		case (op)
			OP_ADD_EDGE: begin
				if (from_blk < n && to_blk < n) edge_rows[to_blk][from_blk] = 1'b1;
			end
			OP_CLEAR: begin
				for (int k = 0; k < 32; k++) edge_rows[k] = '0;
			end
			OP_COMPUTE: predict_dominators();
			default: ;
		endcase
	endfunction

	task automatic send_item(input logic [1:0] op, input int from_blk, input int to_blk);
		logic [S_TDATA_W-1:0] word;
		word = '0;
		word[FROM_LSB +: BLK_W] = from_blk[BLK_W-1:0];
		word[TO_LSB +: BLK_W] = to_blk[BLK_W-1:0];
		// Each idle cycle is drawn on its own, so the idle share matches the percentage.
		while ($urandom_range(99) < send_gap_pct) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= word;
		s_axis_tuser <= op;
		do @(posedge clk); while (!s_axis_tready);
		apply_item(op, from_blk[BLK_W-1:0], to_blk[BLK_W-1:0]);
	endtask

	// Lets the engine drain so the count register may be written safely.
	task automatic wait_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_blk_total(input int value);
		wait_idle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value[CFG_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		shadow_blk_total = value[CFG_W-1:0];
	endtask

	// Receiver: random stalls, plus a long hold-off on request.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_reports.size() == 0) begin
				$error("block_index: expected none, actual %0d",
					m_axis_tdata[M_IDX_LSB +: BLK_W]);
				mismatch_count++;
			end else begin
				seen_report = expected_reports.pop_front();
				if (m_axis_tdata[M_IDX_LSB +: BLK_W] !== seen_report.block_index) begin
					$error("block_index: expected %0d, actual %0d",
						seen_report.block_index, m_axis_tdata[M_IDX_LSB +: BLK_W]);
					mismatch_count++;
				end
				if (m_axis_tdata[M_SET_LSB +: SET_W] !== seen_report.dominator_set) begin
					$error("dominator_set: expected %h, actual %h",
						seen_report.dominator_set, m_axis_tdata[M_SET_LSB +: SET_W]);
					mismatch_count++;
				end
				if (m_axis_tdata[M_IDOM_LSB +: BLK_W] !== seen_report.immediate_dominator) begin
					$error("immediate_dominator: expected %0d, actual %0d",
						seen_report.immediate_dominator, m_axis_tdata[M_IDOM_LSB +: BLK_W]);
					mismatch_count++;
				end
				if (m_axis_tdata[M_HAS_BIT] !== seen_report.has_immediate) begin
					$error("has_immediate: expected %0d, actual %0d",
						seen_report.has_immediate, m_axis_tdata[M_HAS_BIT]);
					mismatch_count++;
				end
				if (m_axis_tlast !== seen_report.last) begin
					$error("last: expected %0d, actual %0d", seen_report.last, m_axis_tlast);
					mismatch_count++;
				end
			end
		end
	end

	// After reset only the entry block is in use.
	task automatic test_reset_state();
		send_item(OP_ADD_EDGE, 0, 0);
		send_item(OP_ADD_EDGE, 1, 0);
		send_item(OP_COMPUTE, 0, 0);
	endtask

	// Diamond with a loop and a back edge, one unreachable block, ignored edges.
	task automatic test_branch_and_loop();
		write_blk_total(6);
		send_item(OP_ADD_EDGE, 0, 1);
		send_item(OP_ADD_EDGE, 0, 2);
		send_item(OP_ADD_EDGE, 1, 3);
		send_item(OP_ADD_EDGE, 2, 3);
		send_item(OP_ADD_EDGE, 3, 4);
		send_item(OP_ADD_EDGE, 4, 3);
		send_item(OP_ADD_EDGE, 4, 1);
		send_item(OP_ADD_EDGE, 0, 1);
		send_item(OP_ADD_EDGE, 31, 2);
		send_item(OP_ADD_EDGE, 2, 31);
		send_item(OP_UNUSED, 31, 31);
		send_item(OP_COMPUTE, 0, 0);
		send_item(OP_CLEAR, 0, 0);
		send_item(OP_COMPUTE, 0, 0);
	endtask

	// Count values below and above the legal range, and a count lowered over stored edges.
	task automatic test_count_extremes();
		write_blk_total(0);
		send_item(OP_COMPUTE, 0, 0);
		write_blk_total(63);
		send_item(OP_ADD_EDGE, 0, 31);
		send_item(OP_ADD_EDGE, 31, 1);
		send_item(OP_COMPUTE, 0, 0);
		write_blk_total(33);
		send_item(OP_COMPUTE, 0, 0);
		write_blk_total(3);
		send_item(OP_COMPUTE, 0, 0);
	endtask

	// The receiver holds off while computes keep coming, so the input must stall.
	task automatic test_output_stall();
		int to_blk;
		write_blk_total(12);
		send_item(OP_CLEAR, 0, 0);
		for (int k = 0; k < 16; k++) begin
			to_blk = $urandom_range(11, 1);
			send_item(OP_ADD_EDGE, $urandom_range(to_blk - 1, 0), to_blk);
		end
		send_gap_pct = 0;
		hold_off_req = 1'b1;
		send_item(OP_COMPUTE, 0, 0);
		send_item(OP_ADD_EDGE, 5, 2);
		send_item(OP_COMPUTE, 0, 0);
		send_item(OP_COMPUTE, 0, 0);
		send_gap_pct = 31;
	endtask

	task automatic test_no_idle_stretch();
		write_blk_total(10);
		send_gap_pct = 0;
		recv_stall_pct = 0;
		for (int k = 0; k < 30; k++) send_item(OP_ADD_EDGE, $urandom_range(9), $urandom_range(9));
		send_item(OP_COMPUTE, 0, 0);
		send_item(OP_COMPUTE, 0, 0);
		send_item(OP_CLEAR, 0, 0);
		send_item(OP_ADD_EDGE, 0, 9);
		send_item(OP_COMPUTE, 0, 0);
		wait_idle();
		send_gap_pct = 31;
		recv_stall_pct = 31;
	endtask

	// Mostly well-formed forward graphs with some cross and back edges, plus noise.
	task automatic test_random_graphs();
		int counted, n, pick, edge_total, from_blk, to_blk;
		counted = 0;
		while (counted < 180) begin
			pick = $urandom_range(99);
			if (pick < 70) write_blk_total($urandom_range(8, 2));
			else if (pick < 90) write_blk_total($urandom_range(20, 9));
			else write_blk_total($urandom_range(63, 32));
			n = effective_blocks();
			if ($urandom_range(3) == 0) begin
				send_item(OP_CLEAR, 0, 0);
				counted++;
			end
			edge_total = $urandom_range(2 * n, n / 2 + 1);
			for (int k = 0; k < edge_total; k++) begin
				pick = $urandom_range(99);
				if (pick < 55) begin
					to_blk = $urandom_range(n - 1, 1);
					from_blk = $urandom_range(to_blk - 1, 0);
					send_item(OP_ADD_EDGE, from_blk, to_blk);
				end else if (pick < 85) begin
					send_item(OP_ADD_EDGE, $urandom_range(n - 1), $urandom_range(n - 1));
				end else if (pick < 95) begin
					from_blk = $urandom_range(31);
					to_blk = $urandom_range(31);
					send_item(OP_ADD_EDGE, from_blk, to_blk);
				end else begin
					send_item(OP_UNUSED, $urandom_range(31), $urandom_range(31));
				end
				counted++;
			end
			send_item(OP_COMPUTE, 0, 0);
			counted++;
			if ($urandom_range(4) == 0) begin
				send_item(OP_ADD_EDGE, $urandom_range(n - 1), $urandom_range(n - 1));
				send_item(OP_COMPUTE, 0, 0);
				counted += 2;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		mismatch_count = 0;
		cycle_count = 0;
		send_gap_pct = 31;
		recv_stall_pct = 31;
		hold_off_req = 1'b0;
		hold_left = 0;
		shadow_blk_total = 1;
		for (int k = 0; k < 32; k++) begin
			edge_rows[k] = '0;
			dom_rows[k] = '0;
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_branch_and_loop();
		test_count_extremes();
		test_output_stall();
		test_no_idle_stretch();
		test_random_graphs();

		wait_idle();
		repeat (50) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule

### filelist.f
+incdir+design
design/dse_pkg.sv
design/dse_ram.sv
design/dominator_set_engine.sv
design/dse_checker.sv
tb/sv/dominator_set_engine_test.sv
